>>> design/meter_frame_header_and_frame_check_assert.svh
// Assertion macros used by the top design file.
`ifndef METER_FRAME_HEADER_AND_FRAME_CHECK_ASSERT_SVH
`define METER_FRAME_HEADER_AND_FRAME_CHECK_ASSERT_SVH

`ifndef ASSERT_OFF

// Checked property, ignored while reset is asserted.
`define MFHC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mfhc assertion failed");

// Checked property, also checked during reset.
`define MFHC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("mfhc assertion failed");

`else

`define MFHC_ASSERT(label, clk, rst_n, prop)
`define MFHC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> design/mfhc_pkg.sv
package mfhc_pkg;

    localparam logic [7:0]  START_BYTE  = 8'h68;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h8408;
    // Register value after a block followed by its own valid complemented check.
    localparam logic [15:0] CRC_RESIDUE = 16'hF0B8;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_START = 3'd1;
    localparam logic [2:0] ST_BAD_HCS   = 3'd2;
    localparam logic [2:0] ST_BAD_FCS   = 3'd3;
    localparam logic [2:0] ST_BAD_LEN   = 3'd4;

    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic        is_apdu;
        logic        frame_done;
        logic [2:0]  status;
        logic [15:0] apdu_length;
    } t_result;

endpackage

>>> design/mfhc_check.sv
module mfhc_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_data_byte,
    input  logic               i_first,
    output mfhc_pkg::t_result  o_result
);

    logic [15:0] r_pos, n_pos;
    logic [15:0] r_flen, n_flen;
    logic [4:0]  r_alen, n_alen;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_low, n_low;
    logic        r_active, n_active;

    logic [15:0] e_pos, e_flen, e_crc;
    logic [4:0]  e_alen;
    logic [7:0]  e_low;
    logic        e_active;
    logic [15:0] w_crc1, w_hcs, w_fcs;
    logic        w_done;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ mfhc_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // A first byte restarts the frame from a cleared state.
    assign e_pos    = i_first ? 16'd0 : r_pos;
    assign e_flen   = i_first ? 16'd0 : r_flen;
    assign e_alen   = i_first ? 5'd0 : r_alen;
    assign e_crc    = i_first ? mfhc_pkg::CRC_INIT : r_crc;
    assign e_low    = i_first ? 8'd0 : r_low;
    assign e_active = i_first | r_active;

    assign w_crc1 = crc_byte(e_crc, i_data_byte);
    assign w_hcs  = {11'd0, e_alen} + 16'd5;
    assign w_fcs  = e_flen - 16'd1;

    always_comb begin
        n_pos    = e_pos;
        n_flen   = e_flen;
        n_alen   = e_alen;
        n_crc    = e_crc;
        n_low    = e_low;
        n_active = e_active;
        w_done   = 1'b0;
        o_result.byte_out    = i_data_byte;
        o_result.is_apdu     = 1'b0;
        o_result.frame_done  = 1'b0;
        o_result.status      = mfhc_pkg::ST_OK;
        o_result.apdu_length = 16'd0;
        if (e_active) begin
            n_pos = e_pos + 16'd1;
            if (e_pos == 16'd0) begin
                if (i_data_byte != mfhc_pkg::START_BYTE) begin
                    w_done = 1'b1;
                    o_result.status = mfhc_pkg::ST_BAD_START;
                end
            end else if (e_pos <= 16'd4) begin
                n_crc = w_crc1;
                if (e_pos == 16'd1) begin
                    n_flen = {8'h00, i_data_byte};
                end else if (e_pos == 16'd2) begin
                    n_flen = {i_data_byte, e_flen[7:0]};
                end else if (e_pos == 16'd4) begin
                    n_alen = {1'b0, i_data_byte[3:0]} + 5'd2;
                    if (e_flen < {11'd0, n_alen} + 16'd8) begin
                        w_done = 1'b1;
                        o_result.status = mfhc_pkg::ST_BAD_LEN;
                    end
                end
            end else if (e_pos < w_hcs) begin
                n_crc = w_crc1;
            end else if (e_pos == w_hcs) begin
                n_low = i_data_byte;
            end else if (e_pos == w_hcs + 16'd1) begin
                if (~e_crc != {i_data_byte, e_low}) begin
                    w_done = 1'b1;
                    o_result.status = mfhc_pkg::ST_BAD_HCS;
                end else begin
                    // Feeding a matching check into the CRC always lands on the residue.
                    n_crc = mfhc_pkg::CRC_RESIDUE;
                end
            end else if (e_pos < w_fcs) begin
                o_result.is_apdu = 1'b1;
                n_crc = w_crc1;
            end else if (e_pos == w_fcs) begin
                n_low = i_data_byte;
            end else begin
                w_done = 1'b1;
                if (~e_crc != {i_data_byte, e_low}) begin
                    o_result.status = mfhc_pkg::ST_BAD_FCS;
                end else begin
                    o_result.apdu_length = e_flen - {11'd0, e_alen} - 16'd8;
                end
            end
            if (w_done) begin
                n_active = 1'b0;
                n_pos    = 16'd0;
                n_flen   = 16'd0;
                n_alen   = 5'd0;
                n_crc    = mfhc_pkg::CRC_INIT;
                n_low    = 8'd0;
            end
        end
        o_result.frame_done = w_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 16'd0;
            r_flen   <= 16'd0;
            r_alen   <= 5'd0;
            r_crc    <= mfhc_pkg::CRC_INIT;
            r_low    <= 8'd0;
            r_active <= 1'b0;
        end else if (i_step) begin
            r_pos    <= n_pos;
            r_flen   <= n_flen;
            r_alen   <= n_alen;
            r_crc    <= n_crc;
            r_low    <= n_low;
            r_active <= n_active;
        end
    end

endmodule

>>> design/meter_frame_header_and_frame_check.sv
// Channel  | Dir | tdata (low bit up)                              | tuser   | tlast
// s_axis   | in  | data_byte[7:0]                                  | first   | -
// m_axis   | out | byte_out[7:0], status[10:8], apdu_length[26:11] | is_apdu | frame_done
//
// One byte per cycle sustained while m_axis does not stall.
// An input register feeds one CRC-byte update and the position compares, which
// write the output register. Reset is synchronous, active low, and clears the
// frame state. A stall on m_axis holds both registers; s_axis stays ready while
// either register can move.
`include "meter_frame_header_and_frame_check_assert.svh"

module meter_frame_header_and_frame_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // data_byte[7:0]
    input  logic                                s_axis_tuser,  // first
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // byte_out[7:0], status[10:8], apdu_length[26:11], zeros above
    output logic [mfhc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tuser,  // is_apdu
    output logic                                m_axis_tlast   // frame_done
);

    logic              r_iv;
    logic [7:0]        r_ibyte;
    logic              r_ifirst;
    logic              r_ov;
    mfhc_pkg::t_result r_out;
    mfhc_pkg::t_result w_res;
    logic              w_out_load;
    logic              w_step;

    assign w_out_load    = !r_ov || m_axis_tready;
    assign w_step        = r_iv && w_out_load;
    assign s_axis_tready = !r_iv || w_out_load;

    mfhc_check u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_data_byte (r_ibyte),
        .i_first     (r_ifirst),
        .o_result    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_iv <= s_axis_tvalid;
            end
            if (w_out_load) begin
                r_ov <= r_iv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_ibyte  <= s_axis_tdata;
            r_ifirst <= s_axis_tuser;
        end
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{(mfhc_pkg::OUT_TDATA_W - 27){1'b0}},
                            r_out.apdu_length, r_out.status, r_out.byte_out};
    assign m_axis_tuser  = r_out.is_apdu;
    assign m_axis_tlast  = r_out.frame_done;

    // With the output register empty the input side can never be blocked.
    `MFHC_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !r_ov |-> s_axis_tready)
    // A held input transaction moves to the output whenever the output can load.
    `MFHC_ASSERT(a_item_advances, i_clk, i_rst_n, (r_iv && w_out_load) |=> r_ov)
    // A nonzero APDU length only comes with a good verdict.
    `MFHC_ASSERT(a_len_only_ok, i_clk, i_rst_n,
        (r_ov && r_out.apdu_length != 16'd0) |->
        (r_out.frame_done && r_out.status == mfhc_pkg::ST_OK))
    // APDU bytes never carry the verdict.
    `MFHC_ASSERT(a_apdu_not_done, i_clk, i_rst_n, (r_ov && r_out.is_apdu) |-> !r_out.frame_done)

endmodule

>>> test/meter_frame_header_and_frame_check_tb.sv
`timescale 1ns / 100ps

module meter_frame_header_and_frame_check_tb;

    localparam int TOTAL_BYTES  = 1750;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    // Tracks the frame state the same way the block does and keeps the
    // expected output of every accepted byte until the block delivers it.
    class frame_check_scoreboard;
        logic [15:0]       byte_pos;
        logic [15:0]       frame_len;
        logic [4:0]        addr_len;
        logic [15:0]       crc;
        logic [7:0]        low_check;
        bit                active;
        mfhc_pkg::t_result expected_q[$];
        int                errors;
        int                bytes_noted;
        int                results_checked;
        int                verdict_count[5];

        function new();
            clear_frame();
            active = 1'b0;
        endfunction

        static function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {8'h00, b};
            for (int k = 0; k < 8; k++) begin
                if (r[0]) begin
                    r = (r >> 1) ^ mfhc_pkg::CRC_POLY;
                end else begin
                    r = r >> 1;
                end
            end
            return r;
        endfunction

        function void clear_frame();
            byte_pos  = '0;
            frame_len = '0;
            addr_len  = '0;
            crc       = mfhc_pkg::CRC_INIT;
            low_check = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(logic [7:0] b, logic f);
            mfhc_pkg::t_result r;
            int                pos;
            int                hcs_pos;
            int                fcs_pos;
            logic [15:0]       word;
            r = '0;
            r.byte_out = b;
            r.status = mfhc_pkg::ST_OK;
            bytes_noted++;
            if (f) begin
                clear_frame();
                active = 1'b1;
            end
            if (active) begin
                pos = int'(byte_pos);
                if (pos == 0) begin
                    if (b != mfhc_pkg::START_BYTE) begin
                        r.frame_done = 1'b1;
                        r.status = mfhc_pkg::ST_BAD_START;
                    end
                end else if (pos <= 4) begin
                    crc = crc_update(crc, b);
                    if (pos == 1) begin
                        frame_len = {8'h00, b};
                    end else if (pos == 2) begin
                        frame_len[15:8] = b;
                    end else if (pos == 4) begin
                        addr_len = {1'b0, b[3:0]} + 5'd2;
                        if (int'(frame_len) < int'(addr_len) + 8) begin
                            r.frame_done = 1'b1;
                            r.status = mfhc_pkg::ST_BAD_LEN;
                        end
                    end
                end else begin
                    hcs_pos = int'(addr_len) + 5;
                    fcs_pos = int'(frame_len) - 1;
                    if (pos < hcs_pos) begin
                        crc = crc_update(crc, b);
                    end else if (pos == hcs_pos) begin
                        low_check = b;
                    end else if (pos == hcs_pos + 1) begin
                        word = {b, low_check};
                        if (~crc != word) begin
                            r.frame_done = 1'b1;
                            r.status = mfhc_pkg::ST_BAD_HCS;
                        end else begin
                            crc = crc_update(crc_update(crc, low_check), b);
                        end
                    end else if (pos < fcs_pos) begin
                        r.is_apdu = 1'b1;
                        crc = crc_update(crc, b);
                    end else if (pos == fcs_pos) begin
                        low_check = b;
                    end else begin
                        word = {b, low_check};
                        r.frame_done = 1'b1;
                        if (~crc != word) begin
                            r.status = mfhc_pkg::ST_BAD_FCS;
                        end else begin
                            r.apdu_length = frame_len - {11'd0, addr_len} - 16'd8;
                        end
                    end
                end
                byte_pos = byte_pos + 16'd1;
                if (r.frame_done) begin
                    active = 1'b0;
                    clear_frame();
                    verdict_count[r.status]++;
                end
            end
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [mfhc_pkg::OUT_TDATA_W-1:0] tdata, logic tuser,
                                   logic tlast);
            mfhc_pkg::t_result exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t ns: unexpected output transaction, expected none, actual %0h",
                         $time, tdata);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            results_checked++;
            compare_field("byte_out", 32'(exp_r.byte_out), 32'(tdata[7:0]));
            compare_field("status", 32'(exp_r.status), 32'(tdata[10:8]));
            compare_field("apdu_length", 32'(exp_r.apdu_length), 32'(tdata[26:11]));
            compare_field("tdata padding", 32'd0, 32'(tdata[mfhc_pkg::OUT_TDATA_W-1:27]));
            compare_field("is_apdu", 32'(exp_r.is_apdu), 32'(tuser));
            compare_field("frame_done", 32'(exp_r.frame_done), 32'(tlast));
        endfunction
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [7:0]                       s_axis_tdata;   // data_byte[7:0]
    logic                             s_axis_tuser;   // first
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    // byte_out[7:0], status[10:8], apdu_length[26:11]
    logic [mfhc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tuser;   // is_apdu
    logic                             m_axis_tlast;   // frame_done

    frame_check_scoreboard sb = new();

    logic [7:0] frame_buf[$];
    int         sent_bytes;
    int         phase;
    int         send_idle_pct;
    int         recv_stall_pct;
    bit         hold_pending;
    bit         hold_done;
    int         quiet_cycles;

    meter_frame_header_and_frame_check DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // Both handshakes are sampled here, before any update of this edge lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_input(s_axis_tdata, s_axis_tuser);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("%0t ns: no transaction for %0d cycles", $time, quiet_cycles);
                    $display("FAILED: results differ");
                    $finish;
                end
            end
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic f);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= f;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_bytes++;
    endtask

    task automatic send_buf(input int count);
        for (int i = 0; i < count; i++) begin
            send_byte(frame_buf[i], i == 0);
        end
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Inverted CRC over everything built so far, leaving out the start byte.
    function automatic logic [15:0] buf_check();
        logic [15:0] c;
        c = mfhc_pkg::CRC_INIT;
        for (int i = 1; i < frame_buf.size(); i++) begin
            c = frame_check_scoreboard::crc_update(c, frame_buf[i]);
        end
        return ~c;
    endfunction

    function automatic void build_frame(input int nib, input int apdu_len);
        int          len;
        logic [15:0] c;
        len = nib + 2 + 8 + apdu_len;
        frame_buf.delete();
        frame_buf.push_back(mfhc_pkg::START_BYTE);
        frame_buf.push_back(len[7:0]);
        frame_buf.push_back(len[15:8]);
        frame_buf.push_back(8'($urandom));
        frame_buf.push_back({4'($urandom), 4'(nib)});
        repeat (nib + 2) frame_buf.push_back(8'($urandom));
        c = buf_check();
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
        repeat (apdu_len) frame_buf.push_back(8'($urandom));
        c = buf_check();
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
    endfunction

    task automatic update_phase();
        int p;
        p = sent_bytes * 4 / TOTAL_BYTES;
        if (p > 3) p = 3;
        if (p != phase) begin
            wait_all_results();
            phase = p;
            send_idle_pct  = (p == 1) ? 53 : (p == 3) ? 38 : 0;
            recv_stall_pct = (p == 2) ? 53 : (p == 3) ? 38 : 0;
        end
        // With the sender never idle, a long hold-off backs the block up.
        if (phase == 0 && !hold_done && sent_bytes >= 150) begin
            hold_pending = 1'b1;
            hold_done = 1'b1;
        end
    endtask

    initial begin
        int         kind;
        int         nib;
        int         apdu_len;
        int         sel;
        int         idx;
        int         last_idx;
        int         bad_len;
        logic [7:0] b;

        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        phase          = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Shortest legal frame with an empty APDU, then bytes while idle.
        build_frame(0, 0);
        send_buf(frame_buf.size());
        send_byte(8'h16, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        // Wrong start byte.
        send_byte(8'hFF, 1'b1);
        // Length too short for the address field.
        build_frame(0, 0);
        frame_buf[1] = 8'h09;
        send_buf(5);
        // Widest address, cut off by the next frame's first byte.
        build_frame(15, 3);
        send_buf(3);

        while (sent_bytes < TOTAL_BYTES) begin
            update_phase();
            kind = $urandom_range(0, 99);
            nib  = $urandom_range(0, 15);
            sel  = $urandom_range(0, 99);
            if (sel < 2) begin
                apdu_len = $urandom_range(240, 300);
            end else if (sel < 12) begin
                apdu_len = $urandom_range(13, 60);
            end else begin
                apdu_len = $urandom_range(0, 12);
            end
            build_frame(nib, apdu_len);
            last_idx = frame_buf.size() - 1;
            if (kind < 65) begin
                send_buf(frame_buf.size());
                if ($urandom_range(0, 3) == 0) send_byte(8'h16, 1'b0);
            end else if (kind < 73) begin
                // Single bit error in the header, in the frame check, or anywhere after
                // the header check.
                case ($urandom_range(0, 2))
                    0:       idx = $urandom_range(1, nib + 8);
                    1:       idx = $urandom_range(last_idx - 1, last_idx);
                    default: idx = $urandom_range(nib + 9, last_idx);
                endcase
                frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
                send_buf(frame_buf.size());
            end else if (kind < 79) begin
                send_buf($urandom_range(1, last_idx));
            end else if (kind < 84) begin
                do b = 8'($urandom); while (b == mfhc_pkg::START_BYTE);
                frame_buf[0] = b;
                send_buf($urandom_range(1, 4));
            end else if (kind < 89) begin
                bad_len = $urandom_range(0, nib + 9);
                frame_buf[1] = bad_len[7:0];
                frame_buf[2] = 8'h00;
                send_buf(5);
            end else if (kind < 95) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom));
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes, checked %0d output transactions across four handshake phases.",
                 sb.bytes_noted, sb.results_checked);
        $display("Verdicts: ok %0d, bad start %0d, bad HCS %0d, bad FCS %0d, bad length %0d.",
                 sb.verdict_count[mfhc_pkg::ST_OK], sb.verdict_count[mfhc_pkg::ST_BAD_START],
                 sb.verdict_count[mfhc_pkg::ST_BAD_HCS], sb.verdict_count[mfhc_pkg::ST_BAD_FCS],
                 sb.verdict_count[mfhc_pkg::ST_BAD_LEN]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
